// ----- src/vpmi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpmi_pkg
// Shared constants, slot codes, controller state codes and the command and
// status types of the video memory access port.
// ----------------------------------------------------------------------------
package vpmi_pkg;

    localparam int ADDR_BITS = 16;
    localparam int MEM_WORDS = 1 << ADDR_BITS;
    localparam int WORD_BITS = 16;

    // Register slots (bus byte offset divided by two).
    localparam logic [2:0] SLOT_POINTER = 3'd0;
    localparam logic [2:0] SLOT_DATA    = 3'd1;
    localparam logic [2:0] SLOT_MODULO  = 3'd2;
    localparam logic [2:0] SLOT_STATUS  = 3'd3;
    localparam logic [2:0] SLOT_IRQ_POS = 3'd4;
    localparam logic [2:0] SLOT_IRQ_HI  = 3'd5;
    localparam logic [2:0] SLOT_IRQ_ACK = 3'd6;
    localparam logic [2:0] SLOT_SPARE   = 3'd7;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Status reads always show this bit set.
    localparam logic [WORD_BITS-1:0] STATUS_FIXED = 16'h0080;

    // Controller states.
    localparam logic [0:0] ST_IDLE     = 1'b0;
    localparam logic [0:0] ST_MEM_READ = 1'b1;

    typedef struct packed {
        logic take;         // item accepted this cycle
        logic load_direct;  // load output register from the slot decode
        logic load_mem;     // load output register from the memory read data
    } vpmi_cmd_t;

    typedef struct packed {
        logic mem_read;     // the offered item reads the video store
    } vpmi_stat_t;

endpackage

// ----- src/vpmi_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpmi_ctrl
// Controller: input and output handshakes, the memory read wait state and
// the output valid flag.
// ----------------------------------------------------------------------------
module vpmi_ctrl
    import vpmi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  vpmi_stat_t stat,
    output vpmi_cmd_t  cmd
);

    logic [0:0] state_reg;
    logic [0:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    // A new item waits while a read is in flight or the result is not taken.
    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.take        = accept;
        cmd.load_direct = accept && !stat.mem_read;
        cmd.load_mem    = (state_reg == ST_MEM_READ);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && stat.mem_read)
                begin
                    state_next = ST_MEM_READ;
                end
            end
            ST_MEM_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.load_direct || cmd.load_mem)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- src/vpmi_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpmi_datapath
// Datapath: slot decode, pointer, modulo and speed registers, the video
// store and the output data register.
// ----------------------------------------------------------------------------
module vpmi_datapath
    import vpmi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 operation,
    input  logic [2:0]           reg_select,
    input  logic [WORD_BITS-1:0] write_data,
    input  logic [2:0]           frame_phase,
    input  vpmi_cmd_t            cmd,
    output vpmi_stat_t           stat,
    output logic [WORD_BITS-1:0] read_data
);

    logic [WORD_BITS-1:0] mem [0:MEM_WORDS-1];

    logic [WORD_BITS-1:0] pointer_reg;
    logic [WORD_BITS-1:0] pointer_next;
    logic [WORD_BITS-1:0] step_reg;
    logic [WORD_BITS-1:0] step_next;
    logic [7:0]           speed_reg;
    logic [7:0]           speed_next;
    logic [WORD_BITS-1:0] mem_rd_reg;
    logic [WORD_BITS-1:0] read_data_reg;
    logic [WORD_BITS-1:0] direct_result;
    logic [ADDR_BITS-1:0] mem_addr;
    logic                 mem_write;

    assign mem_addr  = pointer_reg[ADDR_BITS-1:0];
    assign mem_write = cmd.take && (operation == OP_WRITE) && (reg_select == SLOT_DATA);
    assign read_data = read_data_reg;

    always_comb
    begin
        stat.mem_read = 1'b0;
        if (operation == OP_READ)
        begin
            unique case (reg_select)
                SLOT_POINTER, SLOT_DATA, SLOT_IRQ_POS, SLOT_IRQ_HI:
                    stat.mem_read = 1'b1;
                default:
                    stat.mem_read = 1'b0;
            endcase
        end
    end

    // Results that do not come from the store; writes always return zero.
    always_comb
    begin
        direct_result = '0;
        if (operation == OP_READ)
        begin
            unique case (reg_select)
                SLOT_MODULO:
                    direct_result = step_reg;
                SLOT_STATUS:
                    direct_result = {speed_reg, 5'd0, frame_phase} | STATUS_FIXED;
                default:
                    direct_result = '0;
            endcase
        end
    end

    always_comb
    begin
        pointer_next = pointer_reg;
        step_next    = step_reg;
        speed_next   = speed_reg;
        if (cmd.take && (operation == OP_WRITE))
        begin
            unique case (reg_select)
                SLOT_POINTER:
                    pointer_next = write_data;
                SLOT_DATA:
                    pointer_next = pointer_reg + step_reg;
                SLOT_MODULO:
                    step_next = write_data;
                SLOT_STATUS:
                    speed_next = write_data[15:8];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pointer_reg <= '0;
            step_reg    <= '0;
            speed_reg   <= '0;
        end
        else
        begin
            pointer_reg <= pointer_next;
            step_reg    <= step_next;
            speed_reg   <= speed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_write)
        begin
            mem[mem_addr] <= write_data;
        end
        if (cmd.take && stat.mem_read)
        begin
            mem_rd_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_direct)
        begin
            read_data_reg <= direct_result;
        end
        else if (cmd.load_mem)
        begin
            read_data_reg <= mem_rd_reg;
        end
    end

endmodule

// ----- src/vram_port_modulo_increment.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vram_port_modulo_increment
// Video memory access port behind word registers: pointer, data with modulo
// step, modulo and frame status slots over a word-addressed video store.
// ----------------------------------------------------------------------------
//  Channel | Handshake           | Payload
//  --------+---------------------+--------------------------------------------
//  input   | in_valid / in_stall | operation, reg_select, write_data, frame_phase
//  output  | out_valid/out_stall | read_data
//
// Register, status and write items load the output register directly; store
// reads go through the registered read port of the video store and a wait state.
// The result sits in an output register; the next item is taken while it
// waits unless out_stall holds it.
// Reset clears pointer, modulo and speed; the store itself is not cleared.
// ----------------------------------------------------------------------------
module vram_port_modulo_increment
    import vpmi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 operation,
    input  logic [2:0]           reg_select,
    input  logic [WORD_BITS-1:0] write_data,
    input  logic [2:0]           frame_phase,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WORD_BITS-1:0] read_data
);

    vpmi_cmd_t  cmd;
    vpmi_stat_t stat;

    vpmi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    vpmi_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .operation   (operation),
        .reg_select  (reg_select),
        .write_data  (write_data),
        .frame_phase (frame_phase),
        .cmd         (cmd),
        .stat        (stat),
        .read_data   (read_data)
    );

endmodule

// ----- src/vpmi_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpmi_checker
// Port-level checks of the video memory access port.
// ----------------------------------------------------------------------------
module vpmi_checker
    import vpmi_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 operation,
    input logic [2:0]           reg_select,
    input logic [2:0]           frame_phase,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [WORD_BITS-1:0] read_data
);

    logic in_take;

    assign in_take = in_valid && !in_stall;

    // A held result blocks new items, so no result can be overwritten.
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("item accepted while a result was held");

    // Every write item answers with zero in the next cycle.
    a_write_returns_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && operation == OP_WRITE) |=> (out_valid && read_data == '0))
        else $error("write item did not return zero");

    // The status slot shows the fixed bit and the sampled frame phase.
    a_status_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && operation == OP_READ && reg_select == SLOT_STATUS) |=>
        (out_valid && read_data[7] && read_data[2:0] == $past(frame_phase)))
        else $error("status read is malformed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(read_data)))
        else $error("stalled result changed");

endmodule

bind vram_port_modulo_increment vpmi_checker u_vpmi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .reg_select  (reg_select),
    .frame_phase (frame_phase),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data)
);
